/* hw/rtl/pidc_pkg.sv */
// shared types, constants and register codes of the clamped pid controller
package pidc_pkg;

  localparam int DATA_W        = 16;
  localparam int GAIN_W        = 18;
  localparam int NUM_SLOTS_DEF = 4;
  localparam int FIFO_DEPTH    = 8;

  // register indexes, byte address is 4 * index
  localparam int REG_W = 3;
  localparam logic [REG_W-1:0] REG_OUTPUT_MAX = 3'd0;
  localparam logic [REG_W-1:0] REG_OUTPUT_MIN = 3'd1;
  localparam logic [REG_W-1:0] REG_GAIN_P     = 3'd2;
  localparam logic [REG_W-1:0] REG_GAIN_I     = 3'd3;
  localparam logic [REG_W-1:0] REG_GAIN_D     = 3'd4;
  localparam logic [REG_W-1:0] REG_MODE       = 3'd5;

  localparam logic MODE_PID  = 1'b0;
  localparam logic MODE_BANG = 1'b1;

  localparam logic signed [DATA_W-1:0] OUTPUT_MAX_RST = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] OUTPUT_MIN_RST = 16'sh8000;

  typedef struct packed {
    logic signed [DATA_W-1:0] output_max;
    logic signed [DATA_W-1:0] output_min;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic                     mode;
  } cfg_t;

endpackage

/* hw/rtl/pidc_slot_mem.sv */
// per-slot state memory with registered read, valid bits and write bypass
module pidc_slot_mem #(
  parameter int DEPTH  = 4,
  parameter int ADDR_W = 2,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld;
  logic              byp_hit;
  logic [DATA_W-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q     <= mem[raddr];
    byp_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      rd_vld  <= 1'b0;
      byp_hit <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld  <= vld[raddr];
      // write landing on the entry being read this edge
      byp_hit <= we && (waddr == raddr);
    end
  end

  assign rdata = byp_hit ? byp_data : (rd_vld ? rd_q : '0);

endmodule

/* hw/rtl/pidc_datapath.sv */
// three-stage pid datapath around the slot state memories
module pidc_datapath #(
  parameter int NUM_SLOTS = pidc_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_W    = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pidc_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  input  logic [1:0]                          slot,
  input  logic signed [pidc_pkg::DATA_W-1:0]  setpoint,
  input  logic signed [pidc_pkg::DATA_W-1:0]  measured,
  output logic                                out_valid,
  output logic [pidc_pkg::DATA_W-1:0]         command
);

  localparam logic [8:0] NUM_SLOTS_V = 9'(NUM_SLOTS);

  function automatic logic signed [15:0] clamp_lim(input logic signed [25:0] v,
                                                    input logic signed [15:0] hi,
                                                    input logic signed [15:0] lo);
    logic signed [25:0] hi_x;
    logic signed [25:0] lo_x;
    hi_x = $signed({{10{hi[15]}}, hi});
    lo_x = $signed({{10{lo[15]}}, lo});
    if (v > hi_x) begin
      clamp_lim = hi;
    end else if (v < lo_x) begin
      clamp_lim = lo;
    end else begin
      clamp_lim = v[15:0];
    end
  endfunction

  // slot index wraps modulo the slot count
  logic [8:0]        slot_x;
  logic [8:0]        slot_red;
  logic [SLOT_W-1:0] in_idx;

  assign slot_x   = {7'd0, slot};
  assign slot_red = (slot_x >= NUM_SLOTS_V) ? (slot_x - NUM_SLOTS_V) : slot_x;
  assign in_idx   = (NUM_SLOTS == 1) ? '0 : slot_red[SLOT_W-1:0];

  // stage 1: error, products
  logic                     s1_v;
  logic [SLOT_W-1:0]        s1_idx;
  logic signed [15:0]       s1_sp;
  logic signed [15:0]       s1_ms;
  logic [15:0]              prev_raw;
  logic signed [15:0]       prev;
  logic signed [16:0]       err;
  logic signed [16:0]       dy;
  logic signed [34:0]       prod_p;
  logic signed [34:0]       prod_i;
  logic signed [34:0]       prod_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= in_idx;
    s1_sp  <= setpoint;
    s1_ms  <= measured;
  end

  pidc_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .ADDR_W(SLOT_W),
    .DATA_W(pidc_pkg::DATA_W)
  ) u_prev_mem (
    .clk  (clk),
    .rst  (rst),
    .raddr(in_idx),
    .rdata(prev_raw),
    .we   (s1_v && (cfg.mode == pidc_pkg::MODE_PID)),
    .waddr(s1_idx),
    .wdata(s1_ms)
  );

  assign prev   = $signed(prev_raw);
  assign err    = $signed({s1_sp[15], s1_sp}) - $signed({s1_ms[15], s1_ms});
  assign dy     = $signed({s1_ms[15], s1_ms}) - $signed({prev[15], prev});
  assign prod_p = $signed({{17{cfg.gain_p[17]}}, cfg.gain_p}) * $signed({{18{err[16]}}, err});
  assign prod_i = $signed({{17{cfg.gain_i[17]}}, cfg.gain_i}) * $signed({{18{err[16]}}, err});
  assign prod_d = $signed({{17{cfg.gain_d[17]}}, cfg.gain_d}) * $signed({{18{dy[16]}}, dy});

  // stage 2: integral update and write-back
  logic                     s2_v;
  logic [SLOT_W-1:0]        s2_idx;
  logic signed [15:0]       s2_sp;
  logic                     s2_lt;
  logic signed [22:0]       s2_pterm;
  logic signed [22:0]       s2_iterm;
  logic signed [22:0]       s2_dterm;
  logic [15:0]              acc_raw;
  logic signed [25:0]       integ_sum;
  logic signed [15:0]       integ_new;
  logic signed [25:0]       pd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  // floor of q12 product is the upper bits
  always_ff @(posedge clk) begin
    s2_idx   <= s1_idx;
    s2_sp    <= s1_sp;
    s2_lt    <= s1_sp < s1_ms;
    s2_pterm <= prod_p[34:12];
    s2_iterm <= prod_i[34:12];
    s2_dterm <= prod_d[34:12];
  end

  pidc_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .ADDR_W(SLOT_W),
    .DATA_W(pidc_pkg::DATA_W)
  ) u_integ_mem (
    .clk  (clk),
    .rst  (rst),
    .raddr(s1_idx),
    .rdata(acc_raw),
    .we   (s2_v && (cfg.mode == pidc_pkg::MODE_PID)),
    .waddr(s2_idx),
    .wdata(integ_new)
  );

  assign integ_sum = $signed({{10{acc_raw[15]}}, acc_raw})
                   + $signed({{3{s2_iterm[22]}}, s2_iterm});
  assign integ_new = clamp_lim(integ_sum, cfg.output_max, cfg.output_min);
  assign pd        = $signed({{3{s2_pterm[22]}}, s2_pterm})
                   - $signed({{3{s2_dterm[22]}}, s2_dterm});

  // stage 3: command sum, clamp, sign guard, mode select
  logic                     s3_v;
  logic signed [15:0]       s3_sp;
  logic                     s3_lt;
  logic signed [25:0]       s3_pd;
  logic signed [15:0]       s3_integ;
  logic signed [25:0]       cmd_sum;
  logic signed [15:0]       cmd_clamp;
  logic                     sp_pos;
  logic                     sp_neg;
  logic                     cmd_pos;
  logic                     cmd_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s3_sp    <= s2_sp;
    s3_lt    <= s2_lt;
    s3_pd    <= pd;
    s3_integ <= integ_new;
  end

  assign cmd_sum   = s3_pd + $signed({{10{s3_integ[15]}}, s3_integ});
  assign cmd_clamp = clamp_lim(cmd_sum, cfg.output_max, cfg.output_min);
  assign sp_pos    = !s3_sp[15] && (s3_sp != 16'sd0);
  assign sp_neg    = s3_sp[15];
  assign cmd_pos   = !cmd_clamp[15] && (cmd_clamp != 16'sd0);
  assign cmd_neg   = cmd_clamp[15];

  always_comb begin
    if (cfg.mode == pidc_pkg::MODE_BANG) begin
      command = s3_lt ? '0 : cfg.output_min;
    end else if ((sp_pos && cmd_neg) || (sp_neg && cmd_pos)) begin
      command = '0;
    end else begin
      command = cmd_clamp;
    end
  end

  assign out_valid = s3_v;

endmodule

/* hw/rtl/pidc_out_fifo.sv */
// result fifo that decouples the datapath from the output stream
module pidc_out_fifo #(
  parameter int DEPTH  = pidc_pkg::FIFO_DEPTH,
  parameter int DATA_W = pidc_pkg::DATA_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W:0]   DEPTH_V = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;
  logic              do_pop;

  assign valid  = (count != '0);
  assign data   = buf_q[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop && (count != DEPTH_V)) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/pid_controller_clamped_unit.sv */
// top level of the multi-slot clamped pid controller
//
// usage
//   s_axis carries one sample item per beat: slot, setpoint, measured.
//   m_axis returns one command item per accepted sample, in order.
//   the apb port holds limits, q6.12 gains and the pid / bang-bang mode;
//   write it only while no item is in flight.
// timing
//   one item per clock sustained while s_axis_tready stays high; a command passes
//   the 3 datapath stages and then the result fifo before m_axis offers it.
//   the rate is set by the per-slot integral read-modify-write: the
//   integral memory is read one stage ahead and a write bypass feeds a
//   same-slot item that follows in the next cycle.
// stall and reset
//   an 8-entry result fifo absorbs stalls on m_axis; s_axis_tready drops
//   only when fifo plus datapath hold 8 items, so input keeps flowing
//   while earlier commands wait.
//   rst (synchronous) restores register defaults, empties the pipeline
//   and fifo, and clears all slot state through valid bits.
module pid_controller_clamped_unit #(
  parameter int NUM_SLOTS = pidc_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // slot[1:0], setpoint[17:2], measured[33:18], zero pad
  // command stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // command[15:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int OCC_W  = $clog2(pidc_pkg::FIFO_DEPTH) + 1;
  localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(pidc_pkg::FIFO_DEPTH);

  // configuration registers
  pidc_pkg::cfg_t              cfg;
  logic [pidc_pkg::REG_W-1:0]  reg_idx;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_max <= pidc_pkg::OUTPUT_MAX_RST;
      cfg.output_min <= pidc_pkg::OUTPUT_MIN_RST;
      cfg.gain_p     <= '0;
      cfg.gain_i     <= '0;
      cfg.gain_d     <= '0;
      cfg.mode       <= pidc_pkg::MODE_PID;
    end else if (cfg_wr) begin
      case (reg_idx)
        pidc_pkg::REG_OUTPUT_MAX: cfg.output_max <= $signed(pwdata[15:0]);
        pidc_pkg::REG_OUTPUT_MIN: cfg.output_min <= $signed(pwdata[15:0]);
        pidc_pkg::REG_GAIN_P:     cfg.gain_p     <= $signed(pwdata[17:0]);
        pidc_pkg::REG_GAIN_I:     cfg.gain_i     <= $signed(pwdata[17:0]);
        pidc_pkg::REG_GAIN_D:     cfg.gain_d     <= $signed(pwdata[17:0]);
        pidc_pkg::REG_MODE:       cfg.mode       <= pwdata[0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // read-back, raw register bits zero-extended
  always_comb begin
    unique case (reg_idx)
      pidc_pkg::REG_OUTPUT_MAX: prdata = {16'd0, cfg.output_max};
      pidc_pkg::REG_OUTPUT_MIN: prdata = {16'd0, cfg.output_min};
      pidc_pkg::REG_GAIN_P:     prdata = {14'd0, cfg.gain_p};
      pidc_pkg::REG_GAIN_I:     prdata = {14'd0, cfg.gain_i};
      pidc_pkg::REG_GAIN_D:     prdata = {14'd0, cfg.gain_d};
      pidc_pkg::REG_MODE:       prdata = {31'd0, cfg.mode};
      default:                  prdata = '0;
    endcase
  end

  // occupancy credit: items in the datapath plus items in the fifo
  logic             in_acc;
  logic             out_acc;
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;

  assign s_axis_tready = (occ < OCC_MAX);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_comb begin
    occ_next = occ;
    if (in_acc && !out_acc) begin
      occ_next = occ + 1'b1;
    end else if (!in_acc && out_acc) begin
      occ_next = occ - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // datapath
  logic        dp_valid;
  logic [15:0] dp_command;

  pidc_datapath #(
    .NUM_SLOTS(NUM_SLOTS),
    .SLOT_W   (SLOT_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_acc),
    .slot     (s_axis_tdata[1:0]),
    .setpoint ($signed(s_axis_tdata[17:2])),
    .measured ($signed(s_axis_tdata[33:18])),
    .out_valid(dp_valid),
    .command  (dp_command)
  );

  // result fifo, credit keeps it from overflowing
  pidc_out_fifo #(
    .DEPTH (pidc_pkg::FIFO_DEPTH),
    .DATA_W(pidc_pkg::DATA_W)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (dp_valid),
    .push_data(dp_command),
    .pop      (m_axis_tready),
    .valid    (m_axis_tvalid),
    .data     (m_axis_tdata)
  );

endmodule

/* hw/rtl/pidc_checker.sv */
// port-level checks of the pid controller, bound to the top level
module pidc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        pready
);

  // a held command stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("command item dropped while stalled");

  // a held command keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("command item changed while stalled");

  // every accepted sample has a command on offer once it has passed the datapath and the fifo
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> ##4 m_axis_tvalid)
    else $error("no command four cycles after accepted sample");

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("command offered right after reset");

  // the configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind pid_controller_clamped_unit pidc_checker u_pidc_checker (.*);

/* tb/pidc_command_scoreboard_pkg.sv */
// scoreboard class that predicts and checks the pid controller commands
`timescale 1ns / 1ps
package pidc_command_scoreboard_pkg;
  import pidc_pkg::*;

  class command_scoreboard;
    cfg_t                     regs;
    logic signed [DATA_W-1:0] integ_acc [NUM_SLOTS_DEF];
    logic signed [DATA_W-1:0] last_meas [NUM_SLOTS_DEF];
    logic        [DATA_W-1:0] expected_cmds [$];
    int unsigned              errors;
    int unsigned              n_results;

    function new();
      regs.output_max = OUTPUT_MAX_RST;
      regs.output_min = OUTPUT_MIN_RST;
      regs.gain_p     = '0;
      regs.gain_i     = '0;
      regs.gain_d     = '0;
      regs.mode       = MODE_PID;
      foreach (integ_acc[k]) begin
        integ_acc[k] = '0;
        last_meas[k] = '0;
      end
      errors    = 0;
      n_results = 0;
    endfunction

    function void write_reg(logic [REG_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_OUTPUT_MAX: regs.output_max = val[DATA_W-1:0];
        REG_OUTPUT_MIN: regs.output_min = val[DATA_W-1:0];
        REG_GAIN_P:     regs.gain_p     = val[GAIN_W-1:0];
        REG_GAIN_I:     regs.gain_i     = val[GAIN_W-1:0];
        REG_GAIN_D:     regs.gain_d     = val[GAIN_W-1:0];
        REG_MODE:       regs.mode       = val[0];
        default: ;
      endcase
    endfunction

    // upper limit is tested first, so inverted limits still give a 16-bit value
    function longint limit_to_range(longint v);
      longint hi;
      longint lo;
      hi = longint'($signed(regs.output_max));
      lo = longint'($signed(regs.output_min));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void note_sample(logic [1:0] slot, logic signed [DATA_W-1:0] sp,
                              logic signed [DATA_W-1:0] ms);
      int unsigned s;
      longint      err;
      longint      dy;
      longint      integ;
      longint      cmd;
      longint      kp;
      longint      ki;
      longint      kd;
      s  = slot % NUM_SLOTS_DEF;
      kp = longint'($signed(regs.gain_p));
      ki = longint'($signed(regs.gain_i));
      kd = longint'($signed(regs.gain_d));
      if (regs.mode == MODE_BANG) begin
        // slot state untouched in bang-bang mode
        cmd = (sp < ms) ? 0 : longint'($signed(regs.output_min));
      end else begin
        err   = longint'(sp) - longint'(ms);
        dy    = longint'(ms) - longint'(last_meas[s]);
        integ = longint'(integ_acc[s]) + ((ki * err) >>> 12);
        integ = limit_to_range(integ);
        integ_acc[s] = integ[DATA_W-1:0];
        cmd = ((kp * err) >>> 12) + integ - ((kd * dy) >>> 12);
        cmd = limit_to_range(cmd);
        if (sp > 0 && cmd < 0)
          cmd = 0;
        else if (sp < 0 && cmd > 0)
          cmd = 0;
        last_meas[s] = ms;
      end
      expected_cmds.push_back(cmd[DATA_W-1:0]);
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_command(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("command %0d arrived with no sample pending",
                                  $signed(got)));
        return;
      end
      want = expected_cmds.pop_front();
      if (got !== want)
        report_mismatch($sformatf("command #%0d is %0d, predicted %0d", n_results,
                                  $signed(got), $signed(want)));
      n_results++;
    endtask
  endclass

endpackage

/* tb/testbench.sv */
// top level testbench of the clamped multi-slot pid controller
`timescale 1ns / 1ps
module testbench;
  import pidc_pkg::*;
  import pidc_command_scoreboard_pkg::*;

  // a command follows its sample through the datapath plus any fifo wait
  localparam int LATENCY    = 4;
  localparam int CYCLE_CAP  = 400000;
  localparam int RECV_HOLD  = 80;
  localparam int SEG_ITEMS  = 225;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [39:0] s_axis_tdata = '0;     // slot[1:0], setpoint[17:2], measured[33:18], zero pad
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [15:0] m_axis_tdata;          // command[15:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  command_scoreboard board;

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // long receiver hold, started by the stimulus and timed by the receiver
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int cycles       = 0;

  pid_controller_clamped_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // command side: check each accepted item, then pick tready for the next cycle
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_command(m_axis_tdata);
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_request) begin
      // long stall so the result fifo fills and s_axis_tready drops
      hold_request = 1'b0;
      hold_left = RECV_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic cfg_t make_cfg(int hi, int lo, int gp, int gi, int gd, logic m);
    cfg_t c;
    c.output_max = hi[15:0];
    c.output_min = lo[15:0];
    c.gain_p     = gp[17:0];
    c.gain_i     = gi[17:0];
    c.gain_d     = gd[17:0];
    c.mode       = m;
    return c;
  endfunction

  // modest gains half the time so the loop stays out of saturation, else full range or extremes
  function automatic int rand_gain();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 262143)) - 131072;
      3: begin
        case ($urandom_range(0, 3))
          0: return 131071;
          1: return -131072;
          2: return 0;
          default: return 4096;
        endcase
      end
      default: return int'($urandom_range(0, 16384)) - 8192;
    endcase
  endfunction

  // first segments pin the extremes, the rest are random settings
  function automatic cfg_t pick_cfg(int seg);
    int hi;
    int lo;
    int pick;
    case (seg)
      0: return make_cfg(32767, -32768, 131071, 131071, 131071, MODE_PID);
      1: return make_cfg(-32768, 32767, -131072, -131072, -131072, MODE_PID);
      2: return make_cfg(32767, 32767, rand_gain(), rand_gain(), rand_gain(), MODE_BANG);
      default: begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          hi = $urandom_range(0, 32767);
          lo = -int'($urandom_range(0, 32768));
        end else if (pick < 8) begin
          hi = 32767;
          lo = -32768;
        end else begin
          // arbitrary, may come out inverted
          hi = int'($urandom_range(0, 65535)) - 32768;
          lo = int'($urandom_range(0, 65535)) - 32768;
        end
        return make_cfg(hi, lo, rand_gain(), rand_gain(), rand_gain(),
                        ($urandom_range(0, 99) < 15) ? MODE_BANG : MODE_PID);
      end
    endcase
  endfunction

  // setup cycle, access cycle, then the bus goes idle
  task automatic apb_write(logic [REG_W-1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic program_regs(cfg_t c);
    apb_write(REG_OUTPUT_MAX, 32'($signed(c.output_max)));
    apb_write(REG_OUTPUT_MIN, 32'($signed(c.output_min)));
    apb_write(REG_GAIN_P, 32'($signed(c.gain_p)));
    apb_write(REG_GAIN_I, 32'($signed(c.gain_i)));
    apb_write(REG_GAIN_D, 32'($signed(c.gain_d)));
    apb_write(REG_MODE, {31'b0, c.mode});
  endtask

  // offer one sample after a random gap and wait for it to be taken
  task automatic send_sample(int slot, int sp, int ms);
    logic [1:0]          s;
    logic signed [15:0]  sp16;
    logic signed [15:0]  ms16;
    s    = slot[1:0];
    sp16 = sp[15:0];
    ms16 = ms[15:0];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, ms16, sp16, s};
    do @(posedge clk); while (!s_axis_tready);
    board.note_sample(s, sp16, ms16);
  endtask

  // stop offering and let every pending command come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic run_segment(int n, int hold_at, int pause_at);
    int sp;
    int ms;
    int r;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at)
        hold_request = 1'b1;
      if (i == pause_at) begin
        // sender waits until the block has handed back everything
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
      end
      r = $urandom_range(0, 9);
      if (r == 0)
        sp = $urandom_range(0, 1) ? 32767 : -32768;
      else if (r < 4)
        sp = int'($urandom_range(0, 65535)) - 32768;
      else
        sp = int'($urandom_range(0, 2000)) - 1000;
      // measurement tracks the setpoint in four of ten draws, like a loop near settling
      r = $urandom_range(0, 9);
      if (r < 4)
        ms = sat16(sp + int'($urandom_range(0, 400)) - 200);
      else if (r < 7)
        ms = int'($urandom_range(0, 65535)) - 32768;
      else if (r < 9)
        ms = int'($urandom_range(0, 2000)) - 1000;
      else
        ms = $urandom_range(0, 1) ? 32767 : -32768;
      send_sample($urandom_range(0, 3), sp, ms);
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full range limits, unit proportional gain, integral gain at its positive end, derivative gain at its negative end
    program_regs(make_cfg(32767, -32768, 4096, 131071, -131072, MODE_PID));
    send_sample(0, 32767, -32768);
    send_sample(1, -32768, 32767);
    send_sample(2, 0, 0);
    send_sample(3, 32767, 32767);
    send_sample(0, -32768, -32768);
    // same slot back to back exercises the integral bypass
    send_sample(0, 100, -50);
    send_sample(0, 100, -50);
    // sign guard: positive setpoint with negative drive and the mirror case
    send_sample(1, 5, 200);
    send_sample(2, -5, -300);
    send_sample(3, 0, 1234);
    drain();

    // inverted limits, the upper limit is tested first
    program_regs(make_cfg(-100, 100, 131071, -131072, 131071, MODE_PID));
    send_sample(0, 1000, 0);
    send_sample(1, -1000, 0);
    send_sample(2, 0, 0);
    send_sample(3, 50, -50);
    drain();

    // bang-bang: below, equal, and both extremes
    program_regs(make_cfg(32767, -1234, 0, 0, 0, MODE_BANG));
    send_sample(0, 10, 20);
    send_sample(1, 20, 20);
    send_sample(2, -32768, 32767);
    send_sample(3, 32767, -32768);
    drain();

    // back to pid, slot state must have survived bang-bang mode
    program_regs(make_cfg(32767, -32768, 2048, 4096, 1024, MODE_PID));
    send_sample(0, 7, 7);
    send_sample(1, -7, 7);
    send_sample(2, 300, -300);
    drain();

    // random part: four idling phases, two register settings each
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        program_regs(pick_cfg(ph * 2 + seg));
        run_segment(SEG_ITEMS,
                    (ph == 0 && seg == 0) ? 40 : -1,
                    ((ph == 0 && seg == 1) || (ph == 1 && seg == 0)) ? 100 : -1);
        drain();
      end
    end

    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
